>>> hw/rtl/stb_pkg.sv
// Package for the software timer bank: sizes, command and result codes,
// sequencer states and the divider request/response types.
// Depends on nothing; every module of the block imports it.
package stb_pkg;

	localparam int NUM_TIMERS = 16;
	localparam int IDX_W      = 4;
	localparam int TICK_W     = 32;
	localparam int CNT_W      = 8;
	localparam int SCAN_W     = $clog2(NUM_TIMERS + 1);

	typedef logic [TICK_W-1:0] tick_t;

	typedef enum logic [2:0] {
		MODE_TICK   = 3'd0,
		MODE_CREATE = 3'd1,
		MODE_START  = 3'd2,
		MODE_STOP   = 3'd3,
		MODE_CHANGE = 3'd4,
		MODE_DELETE = 3'd5,
		MODE_SETRL  = 3'd6,
		MODE_QUERY  = 3'd7
	} mode_t;

	typedef enum logic [1:0] {
		KIND_FIRED  = 2'd0,
		KIND_STATUS = 2'd1,
		KIND_REJECT = 2'd2
	} kind_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FIRE_RD,
		ST_FIRE_LD,
		ST_CMD_RD,
		ST_CMD_EXEC,
		ST_RA_CHK,
		ST_RA_DIVA,
		ST_RA_PUTA,
		ST_RA_DIVB,
		ST_RA_NEXT,
		ST_RA_RET,
		ST_WR_EMIT,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic  start;
		tick_t dividend;
		tick_t divisor;
	} div_req_t;

	typedef struct packed {
		logic  done;
		tick_t quotient;
		tick_t remainder;
	} div_rsp_t;

	// Adds a wide count to an 8-bit fire count, saturating at the top.
	function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a, input tick_t b);
		logic [CNT_W:0] s;
		s = {1'b0, a} + {1'b0, b[CNT_W-1:0]};
		if ((|b[TICK_W-1:CNT_W]) || s[CNT_W])
			return {CNT_W{1'b1}};
		return s[CNT_W-1:0];
	endfunction

endpackage

>>> hw/rtl/software_timer_bank_top.sv
// Top level of the software timer bank: command sequencer, timer stores and
// result staging. Depends on stb_pkg and on the iterative divider stb_div.
//
//  channel   | handshake              | payload
//  ----------+------------------------+--------------------------------------------
//  request   | start && !busy         | mode, timer_index, value, reload_on, tick_now
//  result    | strobe (one cycle)     | kind, fired_index, fire_count, is_active,
//            |                        | is_autoreload, expiry_tick, period_ticks, last
//
// A command other than start steps through command read, execute, emit and finish.
// A tick with nothing due scans the timers once and finishes. A wrapped tick first
// drains the current list. Each firing adds read, load and emit steps and a fresh
// scan; an auto-reload timer or a start adds up to three divider passes.
// Results leave one step behind their production so that last can be marked; the
// final one appears in the cycle busy drops. Reset clears all timers. The receiver
// cannot stall; busy holds off new requests while a step runs.
module software_timer_bank_top import stb_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [2:0]         mode,
	input  logic [IDX_W-1:0]   timer_index,
	input  logic [TICK_W-1:0]  value,
	input  logic               reload_on,
	input  logic [TICK_W-1:0]  tick_now,
	output logic               strobe,
	output logic [1:0]         kind,
	output logic [IDX_W-1:0]   fired_index,
	output logic [CNT_W-1:0]   fire_count,
	output logic               is_active,
	output logic               is_autoreload,
	output logic [TICK_W-1:0]  expiry_tick,
	output logic [TICK_W-1:0]  period_ticks,
	output logic               last
);

	state_t state_q, state_d;

	// Request latch.
	mode_t            mode_q;
	logic [IDX_W-1:0] idx_q;
	tick_t            val_q;
	logic             rl_q;
	tick_t            now_q;
	tick_t            last_tick_q;
	logic             wrap_q;
	logic             cur_sel_q;

	// Timer flags.
	logic [NUM_TIMERS-1:0] active_q, reload_q, listed_q, memb_q;

	// Period and expiry stores share one write and one read port.
	tick_t                 per_mem_q [NUM_TIMERS];
	tick_t                 exp_mem_q [NUM_TIMERS];
	logic [NUM_TIMERS-1:0] vld_q;
	tick_t                 rd_per_raw_q, rd_exp_raw_q;
	logic                  rd_vld_q;
	logic [IDX_W-1:0]      rd_addr;
	logic                  wr_en;
	tick_t                 rd_per, rd_exp;

	// Scan.
	logic [SCAN_W-1:0] sc_q;
	logic              best_vld_q;
	logic [IDX_W-1:0]  best_idx_q;
	tick_t             best_exp_q;
	logic [IDX_W-1:0]  sc_j;
	logic              cand, better, fin_vld;

	// Working timer and re-arm state.
	logic [IDX_W-1:0] tgt_q;
	tick_t            per_q, exp_q, ra_e_q;
	logic [CNT_W-1:0] fires_q, cnt_q;
	logic [1:0]       pass_q;
	logic             ret_start_q;
	kind_t            kind_q;

	tick_t           ra_now, nxt, chg_e;
	logic            e_le_now, no_ovf;

	div_req_t div_req;
	div_rsp_t div_rsp;

	// Result staging.
	logic             pend_vld_q;
	kind_t            pend_kind_q;
	logic [IDX_W-1:0] pend_idx_q;
	logic [CNT_W-1:0] pend_cnt_q;
	logic             pend_act_q, pend_rl_q;
	tick_t            pend_exp_q, pend_per_q;
	logic             new_act, new_rl;
	tick_t            new_exp, new_per;

	logic             out_strobe_q, out_last_q;
	kind_t            out_kind_q;
	logic [IDX_W-1:0] out_idx_q;
	logic [CNT_W-1:0] out_cnt_q;
	logic             out_act_q, out_rl_q;
	tick_t            out_exp_q, out_per_q;

	logic accept;

	stb_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign accept = start && (state_q == ST_IDLE);
	assign busy   = (state_q != ST_IDLE);

	assign rd_per = rd_vld_q ? rd_per_raw_q : '0;
	assign rd_exp = rd_vld_q ? rd_exp_raw_q : '0;

	assign sc_j    = IDX_W'(sc_q - 1'b1);
	assign cand    = (sc_q != '0) && listed_q[sc_j] && (memb_q[sc_j] == cur_sel_q) &&
	                 (wrap_q || (rd_exp <= now_q));
	assign better  = cand && (!best_vld_q || (rd_exp < best_exp_q));
	assign fin_vld = best_vld_q || better;

	// During the wrap pass every timer fires against the top of the tick range.
	assign ra_now   = wrap_q ? '1 : now_q;
	assign e_le_now = ra_e_q <= ra_now;
	assign no_ovf   = ra_e_q <= ~per_q;
	assign nxt      = ra_e_q + per_q;
	assign chg_e    = now_q + val_q;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (tick_now < last_tick_q || mode == MODE_TICK)
						state_d = ST_SCAN;
					else
						state_d = ST_CMD_RD;
				end
			end
			ST_SCAN: begin
				if (sc_q == SCAN_W'(NUM_TIMERS)) begin
					if (fin_vld)
						state_d = ST_FIRE_RD;
					else if (wrap_q && mode_q != MODE_TICK)
						state_d = ST_CMD_RD;
					else
						state_d = ST_FINISH;
				end
			end
			ST_FIRE_RD:  state_d = ST_FIRE_LD;
			ST_FIRE_LD:  state_d = reload_q[best_idx_q] ? ST_RA_CHK : ST_WR_EMIT;
			ST_CMD_RD:   state_d = ST_CMD_EXEC;
			ST_CMD_EXEC: begin
				if (mode_q == MODE_START && rd_per != '0)
					state_d = ST_RA_CHK;
				else
					state_d = ST_WR_EMIT;
			end
			ST_RA_CHK: begin
				if (per_q == '0 || pass_q == 2'd3)
					state_d = ST_RA_RET;
				else if (e_le_now)
					state_d = ST_RA_DIVA;
				else if (no_ovf)
					state_d = ST_RA_DIVB;
				else
					state_d = ST_RA_NEXT;
			end
			ST_RA_DIVA: if (div_rsp.done) state_d = ST_RA_PUTA;
			ST_RA_PUTA: state_d = ST_RA_RET;
			ST_RA_DIVB: if (div_rsp.done) state_d = ST_RA_NEXT;
			ST_RA_NEXT: state_d = (nxt <= ra_now) ? ST_RA_CHK : ST_RA_RET;
			ST_RA_RET:  state_d = ST_WR_EMIT;
			ST_WR_EMIT: state_d = (wrap_q || mode_q == MODE_TICK) ? ST_SCAN : ST_FINISH;
			ST_FINISH:  state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		rd_addr          = '0;
		wr_en            = 1'b0;
		div_req.start    = 1'b0;
		div_req.dividend = e_le_now ? (ra_now - ra_e_q) : ~ra_e_q;
		div_req.divisor  = per_q;
		case (state_q)
			ST_SCAN:    rd_addr = sc_q[IDX_W-1:0];
			ST_FIRE_RD: rd_addr = best_idx_q;
			ST_CMD_RD:  rd_addr = idx_q;
			ST_RA_CHK:  div_req.start = (per_q != '0) && (pass_q != 2'd3) && (e_le_now || no_ovf);
			ST_WR_EMIT: wr_en = 1'b1;
			default:    rd_addr = '0;
		endcase
	end

	// Store contents.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			per_mem_q[tgt_q] <= per_q;
			exp_mem_q[tgt_q] <= exp_q;
		end
		rd_per_raw_q <= per_mem_q[rd_addr];
		rd_exp_raw_q <= exp_mem_q[rd_addr];
	end

	assign new_act = (kind_q == KIND_REJECT) ? 1'b0 : active_q[tgt_q];
	assign new_rl  = (kind_q == KIND_REJECT) ? 1'b0 : reload_q[tgt_q];
	assign new_exp = (kind_q == KIND_REJECT) ? '0 : exp_q;
	assign new_per = (kind_q == KIND_REJECT) ? '0 : per_q;

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			last_tick_q  <= '0;
			wrap_q       <= 1'b0;
			cur_sel_q    <= 1'b0;
			active_q     <= '0;
			reload_q     <= '0;
			listed_q     <= '0;
			memb_q       <= '0;
			vld_q        <= '0;
			rd_vld_q     <= 1'b0;
			sc_q         <= '0;
			best_vld_q   <= 1'b0;
			pend_vld_q   <= 1'b0;
			out_strobe_q <= 1'b0;
			out_last_q   <= 1'b0;
		end else begin
			state_q      <= state_d;
			rd_vld_q     <= vld_q[rd_addr];
			out_strobe_q <= 1'b0;
			if (wr_en)
				vld_q[tgt_q] <= 1'b1;

			if (state_q == ST_SCAN) begin
				sc_q <= sc_q + 1'b1;
				if (better)
					best_vld_q <= 1'b1;
			end else begin
				sc_q       <= '0;
				best_vld_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						last_tick_q <= tick_now;
						wrap_q      <= tick_now < last_tick_q;
					end
				end
				ST_SCAN: begin
					if (sc_q == SCAN_W'(NUM_TIMERS) && !fin_vld && wrap_q) begin
						cur_sel_q <= ~cur_sel_q;
						wrap_q    <= 1'b0;
					end
				end
				ST_FIRE_LD: begin
					listed_q[best_idx_q] <= 1'b0;
					if (!reload_q[best_idx_q])
						active_q[best_idx_q] <= 1'b0;
				end
				ST_CMD_EXEC: begin
					case (mode_q)
						MODE_CREATE: begin
							if (val_q != '0) begin
								listed_q[idx_q] <= 1'b0;
								active_q[idx_q] <= 1'b0;
								reload_q[idx_q] <= rl_q;
							end
						end
						MODE_START: begin
							if (rd_per != '0) begin
								listed_q[idx_q] <= 1'b0;
								active_q[idx_q] <= 1'b1;
							end
						end
						MODE_STOP: begin
							listed_q[idx_q] <= 1'b0;
							active_q[idx_q] <= 1'b0;
						end
						MODE_CHANGE: begin
							if (val_q != '0) begin
								active_q[idx_q] <= 1'b1;
								listed_q[idx_q] <= 1'b1;
								memb_q[idx_q]   <= (chg_e > now_q) ? cur_sel_q : ~cur_sel_q;
							end
						end
						MODE_DELETE: begin
							listed_q[idx_q] <= 1'b0;
							active_q[idx_q] <= 1'b0;
							reload_q[idx_q] <= 1'b0;
						end
						MODE_SETRL: reload_q[idx_q] <= rl_q;
						default: ;
					endcase
				end
				ST_RA_CHK: begin
					if (per_q == '0)
						listed_q[tgt_q] <= 1'b0;
				end
				ST_RA_PUTA: begin
					listed_q[tgt_q] <= 1'b1;
					memb_q[tgt_q]   <= (nxt > ra_now) ? cur_sel_q : ~cur_sel_q;
				end
				ST_RA_NEXT: begin
					if (!(nxt <= ra_now)) begin
						listed_q[tgt_q] <= 1'b1;
						memb_q[tgt_q]   <= cur_sel_q;
					end
				end
				ST_RA_RET: begin
					// A one-shot start that is already due fires once and stops.
					if (ret_start_q && fires_q != '0 && !reload_q[tgt_q]) begin
						listed_q[tgt_q] <= 1'b0;
						active_q[tgt_q] <= 1'b0;
					end
				end
				ST_WR_EMIT: begin
					pend_vld_q   <= 1'b1;
					out_strobe_q <= pend_vld_q;
					out_last_q   <= 1'b0;
				end
				ST_FINISH: begin
					pend_vld_q   <= 1'b0;
					out_strobe_q <= pend_vld_q;
					out_last_q   <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	// Datapath.
	always_ff @(posedge clk) begin
		if (state_q == ST_SCAN && better) begin
			best_idx_q <= sc_j;
			best_exp_q <= rd_exp;
		end
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					mode_q <= mode_t'(mode);
					idx_q  <= timer_index;
					val_q  <= value;
					rl_q   <= reload_on;
					now_q  <= tick_now;
				end
			end
			ST_FIRE_LD: begin
				tgt_q       <= best_idx_q;
				per_q       <= rd_per;
				exp_q       <= best_exp_q;
				ra_e_q      <= best_exp_q;
				fires_q     <= '0;
				pass_q      <= 2'd0;
				ret_start_q <= 1'b0;
				kind_q      <= KIND_FIRED;
				cnt_q       <= CNT_W'(1);
			end
			ST_CMD_EXEC: begin
				tgt_q       <= idx_q;
				per_q       <= rd_per;
				exp_q       <= rd_exp;
				kind_q      <= KIND_STATUS;
				cnt_q       <= '0;
				ra_e_q      <= val_q;
				fires_q     <= '0;
				pass_q      <= 2'd0;
				ret_start_q <= 1'b1;
				case (mode_q)
					MODE_CREATE: begin
						if (val_q == '0) begin
							kind_q <= KIND_REJECT;
						end else begin
							per_q <= val_q;
							exp_q <= '0;
						end
					end
					MODE_START: if (rd_per == '0) kind_q <= KIND_REJECT;
					MODE_CHANGE: begin
						if (val_q == '0) begin
							kind_q <= KIND_REJECT;
						end else begin
							per_q <= val_q;
							exp_q <= chg_e;
						end
					end
					MODE_DELETE: begin
						per_q <= '0;
						exp_q <= '0;
					end
					default: ;
				endcase
			end
			ST_RA_CHK: begin
				if (per_q == '0)
					exp_q <= ra_e_q;
			end
			ST_RA_DIVA: begin
				if (div_rsp.done) begin
					fires_q <= sat_add(fires_q, div_rsp.quotient);
					ra_e_q  <= ra_now - div_rsp.remainder;
				end
			end
			ST_RA_PUTA: exp_q <= nxt;
			ST_RA_DIVB: begin
				if (div_rsp.done) begin
					fires_q <= sat_add(fires_q, div_rsp.quotient);
					ra_e_q  <= ~div_rsp.remainder;
				end
			end
			ST_RA_NEXT: begin
				if (nxt <= ra_now) begin
					fires_q <= sat_add(fires_q, TICK_W'(1));
					ra_e_q  <= nxt;
					pass_q  <= pass_q + 1'b1;
				end else begin
					exp_q <= nxt;
				end
			end
			ST_RA_RET: begin
				if (!ret_start_q) begin
					kind_q <= KIND_FIRED;
					cnt_q  <= sat_add(fires_q, TICK_W'(1));
				end else if (fires_q != '0) begin
					kind_q <= KIND_FIRED;
					if (!reload_q[tgt_q]) begin
						exp_q <= val_q + per_q;
						cnt_q <= CNT_W'(1);
					end else begin
						cnt_q <= fires_q;
					end
				end else begin
					kind_q <= KIND_STATUS;
					cnt_q  <= '0;
				end
			end
			ST_WR_EMIT: begin
				out_kind_q  <= pend_kind_q;
				out_idx_q   <= pend_idx_q;
				out_cnt_q   <= pend_cnt_q;
				out_act_q   <= pend_act_q;
				out_rl_q    <= pend_rl_q;
				out_exp_q   <= pend_exp_q;
				out_per_q   <= pend_per_q;
				pend_kind_q <= kind_q;
				pend_idx_q  <= tgt_q;
				pend_cnt_q  <= cnt_q;
				pend_act_q  <= new_act;
				pend_rl_q   <= new_rl;
				pend_exp_q  <= new_exp;
				pend_per_q  <= new_per;
			end
			ST_FINISH: begin
				out_kind_q <= pend_kind_q;
				out_idx_q  <= pend_idx_q;
				out_cnt_q  <= pend_cnt_q;
				out_act_q  <= pend_act_q;
				out_rl_q   <= pend_rl_q;
				out_exp_q  <= pend_exp_q;
				out_per_q  <= pend_per_q;
			end
			default: ;
		endcase
	end

	assign strobe        = out_strobe_q;
	assign kind          = out_kind_q;
	assign fired_index   = out_idx_q;
	assign fire_count    = out_cnt_q;
	assign is_active     = out_act_q;
	assign is_autoreload = out_rl_q;
	assign expiry_tick   = out_exp_q;
	assign period_ticks  = out_per_q;
	assign last          = out_last_q;

	// A result only ever leaves as the consequence of a running step.
	a_strobe_from_step: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(busy))
		else $error("result strobe without a step in progress");

	// The final result of a step coincides with the sequencer going idle.
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && last) |-> !busy)
		else $error("last result while the sequencer is still busy");

	// An accepted request always starts a step.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("accepted request did not start a step");

	// Divider answers arrive only while the sequencer waits for them.
	a_div_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == ST_RA_DIVA || state_q == ST_RA_DIVB))
		else $error("divider finished outside a re-arm wait");

endmodule

>>> hw/rtl/stb_div.sv
// Iterative restoring divider for the timer bank, one quotient bit per cycle.
// Depends on stb_pkg for the tick width and the request/response structs.
module stb_div import stb_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam int STEP_W = $clog2(TICK_W);

	logic              run_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	tick_t             rem_q;
	tick_t             quo_q;
	tick_t             dvs_q;

	logic [TICK_W:0] trial;
	logic [TICK_W:0] diff;
	logic            ge;

	assign trial = {rem_q, quo_q[TICK_W-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign ge    = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				run_q  <= 1'b1;
				step_q <= '0;
			end else if (run_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(TICK_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (run_q) begin
			rem_q <= ge ? diff[TICK_W-1:0] : trial[TICK_W-1:0];
			quo_q <= {quo_q[TICK_W-2:0], ge};
		end
	end

	assign rsp.done      = done_q;
	assign rsp.quotient  = quo_q;
	assign rsp.remainder = rem_q;

endmodule
